// ----- rtl/brf_pkg.sv -----
// Shared types and constants for the byte ring buffer.
`default_nettype none
package brf_pkg;

  localparam int unsigned MAX_BURST = 8;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_SKIP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NODATA  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_READ = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/byte_ring_fifo_burst.sv -----
// Byte ring buffer with burst push, pop, peek and skip requests.
// Steps: a push of n bytes (n >= 1) writes a byte per S_PUSH state, a pop or peek reads
// one per S_READ state, then S_FIN registers the result; a skip, a zero count or a failed
// request goes straight to S_FIN; no output stall. Throughput: one byte per cycle through
// the single-port byte store; a new request is taken in the previous one's result cycle.
// Reset: pointers clear, ring size returns to 256 (or DEPTH if smaller); store is not cleared.
`default_nettype none
module byte_ring_fifo_burst #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [3:0]  in_count,
  input  wire logic [63:0] in_push_bytes,
  output logic             out_valid,
  output logic [63:0]      out_pop_bytes,
  output logic [1:0]       out_status,
  output logic [7:0]       out_fill_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_ring_size
);
  import brf_pkg::*;

  localparam int unsigned PW       = $clog2(DEPTH);
  localparam int unsigned SW       = $clog2(DEPTH + 1);
  localparam int unsigned RST_SIZE = (DEPTH < 256) ? DEPTH : 256;

  logic [7:0] mem [DEPTH];

  state_t        state_r, state_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  req_t          req_r, req_nxt;
  status_t       stat_r, stat_nxt;
  logic [63:0]   data_r, data_nxt;
  logic [63:0]   res_r, res_nxt;
  logic          pend_r, pend_nxt;
  logic [2:0]    pidx_r, pidx_nxt;
  logic [7:0]    rd_data_r;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_bytes_r, out_bytes_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic [7:0]    out_fill_r, out_fill_nxt;

  logic [SW-1:0] fill_cur;
  logic [SW-1:0] free_cur;
  logic [SW-1:0] fill_new;
  logic [3:0]    cnt_sat;
  logic [31:0]   cfg_ext;
  logic          accept;
  logic          mem_we;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [3:0] n,
                                             logic [SW-1:0] sz);
    logic [SW+4:0] s;
    s = (SW + 5)'(p) + (SW + 5)'(n);
    if (s >= (SW + 5)'(sz)) begin
      s = s - (SW + 5)'(sz);
    end
    return PW'(s);
  endfunction

  function automatic logic [SW-1:0] held(logic [PW-1:0] w, logic [PW-1:0] r,
                                         logic [SW-1:0] sz);
    logic [SW:0] d;
    if (w >= r) begin
      d = (SW + 1)'(w) - (SW + 1)'(r);
    end else begin
      d = (SW + 1)'(w) + (SW + 1)'(sz) - (SW + 1)'(r);
    end
    return SW'(d);
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign accept    = start && (state_r == S_IDLE);
  assign cfg_ext   = 32'(cfg_ring_size);
  assign cnt_sat   = (in_count > 4'(MAX_BURST)) ? 4'(MAX_BURST) : in_count;
  assign fill_cur  = held(wp_r, rp_r, size_r);
  assign free_cur  = size_r - SW'(1) - fill_cur;
  assign fill_new  = held(wp_nxt, rp_nxt, size_r);
  assign mem_we    = (state_r == S_PUSH);

  assign out_valid      = out_valid_r;
  assign out_pop_bytes  = out_bytes_r;
  assign out_status     = out_stat_r;
  assign out_fill_level = out_fill_r;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    stat_nxt      = stat_r;
    data_nxt      = data_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    pidx_nxt      = pidx_r;
    out_valid_nxt = 1'b0;
    out_bytes_nxt = out_bytes_r;
    out_stat_nxt  = out_stat_r;
    out_fill_nxt  = out_fill_r;

    if (pend_r) begin
      res_nxt[8*pidx_r +: 8] = rd_data_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt  = req_t'(in_req_type);
          cnt_nxt  = cnt_sat;
          data_nxt = in_push_bytes;
          res_nxt  = '0;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          ptr_nxt  = (req_t'(in_req_type) == REQ_PUSH) ? wp_r : rp_r;
          stat_nxt = ST_OK;
          state_nxt = S_FIN;
          if (req_t'(in_req_type) == REQ_PUSH) begin
            if (32'(free_cur) < 32'(cnt_sat)) begin
              stat_nxt = ST_NOSPACE;
            end else if (cnt_sat != 4'd0) begin
              state_nxt = S_PUSH;
            end
          end else begin
            if (32'(fill_cur) < 32'(cnt_sat)) begin
              stat_nxt = ST_NODATA;
            end else if (cnt_sat != 4'd0 && req_t'(in_req_type) != REQ_SKIP) begin
              state_nxt = S_READ;
            end
          end
        end else if (cfg_valid) begin
          if (cfg_ext < 32'd2) begin
            size_nxt = SW'(2);
          end else if (cfg_ext > 32'(DEPTH)) begin
            size_nxt = SW'(DEPTH);
          end else begin
            size_nxt = SW'(cfg_ext);
          end
          wp_nxt = '0;
          rp_nxt = '0;
        end
      end
      S_PUSH: begin
        ptr_nxt = wrap_add(ptr_r, 4'd1, size_r);
        idx_nxt = idx_r + 3'd1;
        if ({1'b0, idx_r} == cnt_r - 4'd1) begin
          state_nxt = S_FIN;
        end
      end
      S_READ: begin
        pend_nxt = 1'b1;
        pidx_nxt = idx_r;
        ptr_nxt  = wrap_add(ptr_r, 4'd1, size_r);
        idx_nxt  = idx_r + 3'd1;
        if ({1'b0, idx_r} == cnt_r - 4'd1) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        pend_nxt = 1'b0;
        if (stat_r == ST_OK) begin
          case (req_r)
            REQ_PUSH: wp_nxt = ptr_r;
            REQ_POP:  rp_nxt = ptr_r;
            REQ_SKIP: rp_nxt = wrap_add(rp_r, cnt_r, size_r);
            default:  rp_nxt = rp_r;
          endcase
        end
        out_valid_nxt = 1'b1;
        out_bytes_nxt = (stat_r == ST_OK && (req_r == REQ_POP || req_r == REQ_PEEK)) ?
                        res_nxt : 64'd0;
        out_stat_nxt  = stat_r;
        out_fill_nxt  = 8'(fill_new);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SW'(RST_SIZE);
      wp_r        <= '0;
      rp_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    req_r       <= req_nxt;
    stat_r      <= stat_nxt;
    data_r      <= data_nxt;
    res_r       <= res_nxt;
    pidx_r      <= pidx_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_stat_r  <= out_stat_nxt;
    out_fill_r  <= out_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= data_r[8*idx_r +: 8];
    end
    rd_data_r <= mem[ptr_r];
  end

endmodule
`default_nettype wire
